// ----- sv/duty_cycle_capture_8ch_unit_assert.svh -----
// Assertion macros for the duty-cycle capture unit.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef DUTY_CYCLE_CAPTURE_8CH_UNIT_ASSERT_SVH
`define DUTY_CYCLE_CAPTURE_8CH_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define DCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dcc_pkg.sv -----
// Shared types and constants for the duty-cycle capture unit.
// No dependencies; used by the interfaces and the top level.
package dcc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int TIME_W   = 32;
    localparam int TMO_W    = 20;
    localparam int DUTY_W   = 8;
    localparam int MASK_W   = 8;
    localparam int NUM_W    = TIME_W + DUTY_W;   // 255 * time difference
    localparam int REG_W    = 2;
    localparam int CFG_W    = 20;

    localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 20'd10000;

    // capture phases
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_LOW         = 3'd1;
    localparam logic [2:0] PH_HIGH        = 3'd2;
    localparam logic [2:0] PH_STEADY_LOW  = 3'd3;
    localparam logic [2:0] PH_STEADY_HIGH = 3'd4;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // register indexes
    localparam logic [REG_W-1:0] REG_DEVICES_READY = 2'd0;
    localparam logic [REG_W-1:0] REG_AUTO_MASK     = 2'd1;
    localparam logic [REG_W-1:0] REG_TIMEOUT_MS    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_MUL,
        ST_DIV_SAT,
        ST_DIV_STEP,
        ST_CH_WB,
        ST_FINISH
    } t_state;

endpackage

// ----- sv/dcc_if.sv -----
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on dcc_pkg.
interface dcc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [dcc_pkg::TIME_W-1:0]  now_ms;
    logic [dcc_pkg::MASK_W-1:0]  pins;

    modport source (output valid, op, now_ms, pins, input ready);
    modport sink   (input valid, op, now_ms, pins, output ready);
endinterface

interface dcc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        any_change;
    logic [dcc_pkg::MASK_W-1:0]  force_manual_mask;
    logic [dcc_pkg::MASK_W-1:0]  ssr_on_mask;
    logic [dcc_pkg::MASK_W-1:0]  release_auto_mask;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch0;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch1;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch2;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch3;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch4;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch5;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch6;
    logic [dcc_pkg::DUTY_W-1:0]  duty_ch7;

    modport source (output valid, any_change, force_manual_mask, ssr_on_mask,
                    release_auto_mask, duty_ch0, duty_ch1, duty_ch2, duty_ch3,
                    duty_ch4, duty_ch5, duty_ch6, duty_ch7, input ready);
    modport sink   (input valid, any_change, force_manual_mask, ssr_on_mask,
                    release_auto_mask, duty_ch0, duty_ch1, duty_ch2, duty_ch3,
                    duty_ch4, duty_ch5, duty_ch6, duty_ch7, output ready);
endinterface

interface dcc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dcc_pkg::REG_W-1:0]   index;
    logic [dcc_pkg::CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/duty_cycle_capture_8ch_unit.sv -----
// Flow: accept in idle, one scan state per channel, hand off in finish; if devices are not
//   ready, the accept goes straight to finish. A closed period adds multiply, saturation
//   check, 8 restoring divide steps and write-back, all on the shared 40-bit compare/subtract
//   unit; a saturated duty or zero period skips the divide steps. One transaction in flight:
//   no new item is taken until its result is handed off; a result not yet taken holds the next one in finish.
// Reset (i_rst_n low, synchronous): devices_ready 1, auto_mask 0, timeout 10000 ms,
//   all capture state zero, no result pending.
`include "duty_cycle_capture_8ch_unit_assert.svh"

module duty_cycle_capture_8ch_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcc_in_if.sink     i_in,
    dcc_cfg_if.sink    i_cfg,
    dcc_out_if.source  o_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                        r_dev_ready;
    logic [dcc_pkg::MASK_W-1:0]  r_auto;
    logic [dcc_pkg::TMO_W-1:0]   r_timeout;

    // ------------------------------------------------------------------
    // Capture state (per-channel arrays are read at the channel pointer and
    // at fixed places for the duty snapshot)
    // ------------------------------------------------------------------
    logic [dcc_pkg::MASK_W-1:0]  r_latched;
    logic [dcc_pkg::TIME_W-1:0]  r_last_read;
    logic [2:0]                  r_phase [dcc_pkg::CHANNELS];
    logic [dcc_pkg::TIME_W-1:0]  r_ps    [dcc_pkg::CHANNELS];
    logic [dcc_pkg::TIME_W-1:0]  r_le    [dcc_pkg::CHANNELS];
    logic [dcc_pkg::DUTY_W-1:0]  r_duty  [dcc_pkg::CHANNELS];

    // ------------------------------------------------------------------
    // Sequencer and per-transaction working registers
    // ------------------------------------------------------------------
    dcc_pkg::t_state             r_state, n_state;
    logic [dcc_pkg::CH_W-1:0]    r_ch, n_ch;
    logic                        r_op;
    logic [dcc_pkg::TIME_W-1:0]  r_now;
    logic [dcc_pkg::MASK_W-1:0]  r_old;
    logic                        r_any, n_any;
    logic [dcc_pkg::MASK_W-1:0]  r_force, n_force;
    logic [dcc_pkg::MASK_W-1:0]  r_ssr, n_ssr;
    logic [dcc_pkg::MASK_W-1:0]  r_rel, n_rel;

    // divider
    logic [dcc_pkg::TIME_W-1:0]  r_per, n_per;
    logic [dcc_pkg::NUM_W-1:0]   r_rem, n_rem;
    logic [dcc_pkg::NUM_W-1:0]   r_dvs, n_dvs;
    logic [dcc_pkg::DUTY_W-1:0]  r_q, n_q;
    logic [2:0]                  r_bit, n_bit;

    // result register
    logic                        r_out_valid;
    logic                        r_out_any;
    logic [dcc_pkg::MASK_W-1:0]  r_out_force;
    logic [dcc_pkg::MASK_W-1:0]  r_out_ssr;
    logic [dcc_pkg::MASK_W-1:0]  r_out_rel;
    logic [dcc_pkg::DUTY_W-1:0]  r_out_duty [8];
    logic [dcc_pkg::DUTY_W-1:0]  duty_snap  [8];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc, out_free, last_ch, poll_reread;
    logic [dcc_pkg::TIME_W-1:0] reread_at;

    assign i_in.ready  = (r_state == dcc_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign last_ch     = (r_ch == dcc_pkg::CH_W'(dcc_pkg::CHANNELS - 1));

    // poll re-read: wrapped sum against now, unsigned
    assign reread_at   = r_last_read + dcc_pkg::TIME_W'(r_timeout);
    assign poll_reread = (reread_at < i_in.now_ms);

    // ------------------------------------------------------------------
    // Current channel view
    // ------------------------------------------------------------------
    logic [2:0]                  cur_ph;
    logic [dcc_pkg::TIME_W-1:0]  cur_ps, cur_le, elapsed;
    logic [dcc_pkg::DUTY_W-1:0]  cur_duty;
    logic                        cur_bit, steady, tmo, div_start;
    logic [2:0]                  mir;

    assign cur_ph   = r_phase[r_ch];
    assign cur_ps   = r_ps[r_ch];
    assign cur_le   = r_le[r_ch];
    assign cur_duty = r_duty[r_ch];
    assign cur_bit  = r_latched[r_ch];
    assign mir      = 3'd7 - 3'(r_ch);       // mirrored output index
    assign steady   = (cur_ph inside {dcc_pkg::PH_STEADY_LOW, dcc_pkg::PH_STEADY_HIGH});
    // steady-level timeout: low side measured from period start, high from low end
    assign elapsed  = r_now - (cur_bit ? cur_le : cur_ps);
    assign tmo      = (elapsed > dcc_pkg::TIME_W'(r_timeout));
    // closing a period (high phase, pin back low) needs the divider
    assign div_start = (r_op == dcc_pkg::OP_SAMPLE) && (cur_ph == dcc_pkg::PH_HIGH)
                       && !cur_bit;

    // ------------------------------------------------------------------
    // Shared 40-bit compare/subtract unit
    // ------------------------------------------------------------------
    logic [dcc_pkg::NUM_W-1:0] sub_a, sub_b;
    logic [dcc_pkg::NUM_W:0]   sub_res;
    logic                      sub_ge;

    always_comb begin
        sub_a = r_rem;
        sub_b = r_dvs;
        case (r_state)
            dcc_pkg::ST_DIV_MUL: begin
                // 255 * d = (d << 8) - d
                sub_a = {r_rem[dcc_pkg::TIME_W-1:0], 8'd0};
                sub_b = r_rem;
            end
            dcc_pkg::ST_DIV_SAT: begin
                sub_b = {r_per, 8'd0};
            end
            default: ;
        endcase
    end

    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge  = !sub_res[dcc_pkg::NUM_W];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_dev_ready ? dcc_pkg::ST_SCAN : dcc_pkg::ST_FINISH;
                end
            end
            dcc_pkg::ST_SCAN: begin
                if (div_start) begin
                    n_state = dcc_pkg::ST_DIV_MUL;
                end else if (last_ch) begin
                    n_state = dcc_pkg::ST_FINISH;
                end
            end
            dcc_pkg::ST_DIV_MUL: n_state = dcc_pkg::ST_DIV_SAT;
            dcc_pkg::ST_DIV_SAT: begin
                if (r_per == '0 || sub_ge) begin
                    n_state = dcc_pkg::ST_CH_WB;
                end else begin
                    n_state = dcc_pkg::ST_DIV_STEP;
                end
            end
            dcc_pkg::ST_DIV_STEP: begin
                if (r_bit == 3'd0) begin
                    n_state = dcc_pkg::ST_CH_WB;
                end
            end
            dcc_pkg::ST_CH_WB: begin
                n_state = last_ch ? dcc_pkg::ST_FINISH : dcc_pkg::ST_SCAN;
            end
            dcc_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = dcc_pkg::ST_IDLE;
                end
            end
            default: n_state = dcc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control: channel update, masks, divider steps
    // ------------------------------------------------------------------
    logic                        ch_we;
    logic [2:0]                  n_ph;
    logic [dcc_pkg::TIME_W-1:0]  n_ps, n_le;
    logic [dcc_pkg::DUTY_W-1:0]  n_duty;
    logic                        chk_force;

    always_comb begin
        n_ch      = r_ch;
        n_any     = r_any;
        n_force   = r_force;
        n_ssr     = r_ssr;
        n_rel     = r_rel;
        n_per     = r_per;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_q       = r_q;
        n_bit     = r_bit;
        ch_we     = 1'b0;
        chk_force = 1'b0;
        n_ph      = cur_ph;
        n_ps      = cur_ps;
        n_le      = cur_le;
        n_duty    = cur_duty;

        case (r_state)
            dcc_pkg::ST_SCAN: begin
                if (r_op == dcc_pkg::OP_SAMPLE) begin
                    case (cur_ph)
                        dcc_pkg::PH_IDLE, dcc_pkg::PH_STEADY_HIGH: begin
                            if (!cur_bit) begin
                                n_ps   = r_now;
                                n_ph   = dcc_pkg::PH_LOW;
                                n_duty = dcc_pkg::DUTY_MAX;
                            end
                        end
                        dcc_pkg::PH_LOW: begin
                            if (cur_bit) begin
                                // leaving a steady low with no real period start
                                if (cur_duty == dcc_pkg::DUTY_MAX && cur_ps == '0) begin
                                    n_duty = '0;
                                end
                                n_le = r_now;
                                n_ph = dcc_pkg::PH_HIGH;
                            end
                        end
                        dcc_pkg::PH_STEADY_LOW: begin
                            if (cur_bit) begin
                                n_duty = '0;
                                n_ph   = dcc_pkg::PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                    if (div_start) begin
                        n_per = r_now - cur_ps;
                        n_rem = {8'd0, cur_le - cur_ps};
                    end else begin
                        ch_we     = 1'b1;
                        chk_force = 1'b1;
                        n_ch      = r_ch + dcc_pkg::CH_W'(1);
                    end
                end else begin
                    if (!steady) begin
                        if (tmo) begin
                            n_duty = cur_bit ? '0 : dcc_pkg::DUTY_MAX;
                            n_ph   = cur_bit ? dcc_pkg::PH_STEADY_HIGH
                                             : dcc_pkg::PH_STEADY_LOW;
                            n_ps   = '0;
                            n_le   = '0;
                            ch_we  = 1'b1;
                            n_any  = 1'b1;
                        end
                        // any accumulates along the scan
                        if (n_duty == '0 && r_auto[mir] && (r_any || tmo)) begin
                            n_rel[mir] = 1'b1;
                        end
                    end
                    n_ch = r_ch + dcc_pkg::CH_W'(1);
                end
            end
            dcc_pkg::ST_DIV_MUL: begin
                n_rem = sub_res[dcc_pkg::NUM_W-1:0];
            end
            dcc_pkg::ST_DIV_SAT: begin
                n_q   = '0;
                n_bit = 3'd7;
                n_dvs = {1'b0, r_per, 7'd0};
                if (r_per == '0) begin
                    n_q = '0;
                end else if (sub_ge) begin
                    n_q = dcc_pkg::DUTY_MAX;     // quotient would exceed 255
                end
            end
            dcc_pkg::ST_DIV_STEP: begin
                if (sub_ge) begin
                    n_rem = sub_res[dcc_pkg::NUM_W-1:0];
                    n_q   = r_q | (8'd1 << r_bit);
                end
                n_dvs = r_dvs >> 1;
                n_bit = r_bit - 3'd1;
            end
            dcc_pkg::ST_CH_WB: begin
                n_duty    = r_q;
                n_ps      = r_now;
                n_le      = '0;
                n_ph      = dcc_pkg::PH_LOW;
                ch_we     = 1'b1;
                chk_force = 1'b1;
                n_ch      = r_ch + dcc_pkg::CH_W'(1);
            end
            default: ;
        endcase

        // pin change on an auto output with a live duty: force manual, SSR follows
        if (chk_force && n_duty != '0 && r_auto[mir] && (r_old[r_ch] != cur_bit)) begin
            n_force[mir] = 1'b1;
            if (!cur_bit) begin
                n_ssr[mir] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Duty snapshot; channels past CHANNELS read zero
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 8; g++) begin : g_snap
        if (g < dcc_pkg::CHANNELS) begin : g_live
            assign duty_snap[g] = r_duty[g];
        end else begin : g_none
            assign duty_snap[g] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_ready <= 1'b1;
            r_auto      <= '0;
            r_timeout   <= dcc_pkg::TIMEOUT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                dcc_pkg::REG_DEVICES_READY: r_dev_ready <= i_cfg.data[0];
                dcc_pkg::REG_AUTO_MASK:     r_auto      <= i_cfg.data[dcc_pkg::MASK_W-1:0];
                dcc_pkg::REG_TIMEOUT_MS:    r_timeout   <= i_cfg.data[dcc_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_latched   <= '0;
            r_last_read <= '0;
            for (int k = 0; k < dcc_pkg::CHANNELS; k++) begin
                r_phase[k] <= dcc_pkg::PH_IDLE;
                r_ps[k]    <= '0;
                r_le[k]    <= '0;
                r_duty[k]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (in_acc && r_dev_ready) begin
                if (i_in.op == dcc_pkg::OP_SAMPLE || poll_reread) begin
                    r_latched   <= i_in.pins;
                    r_last_read <= i_in.now_ms;
                end
            end

            if (ch_we) begin
                r_phase[r_ch] <= n_ph;
                r_ps[r_ch]    <= n_ps;
                r_le[r_ch]    <= n_le;
                r_duty[r_ch]  <= n_duty;
            end

            if (r_state == dcc_pkg::ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_in.op;
            r_now   <= i_in.now_ms;
            r_old   <= r_latched;
            r_ch    <= '0;
            r_force <= '0;
            r_ssr   <= '0;
            r_rel   <= '0;
            if (!r_dev_ready) begin
                r_any <= 1'b0;
            end else if (i_in.op == dcc_pkg::OP_SAMPLE) begin
                r_any <= 1'b1;
            end else begin
                r_any <= poll_reread && (r_latched != i_in.pins);
            end
        end else begin
            r_ch    <= n_ch;
            r_any   <= n_any;
            r_force <= n_force;
            r_ssr   <= n_ssr;
            r_rel   <= n_rel;
        end
        r_per <= n_per;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_q   <= n_q;
        r_bit <= n_bit;

        if (r_state == dcc_pkg::ST_FINISH && out_free) begin
            r_out_any   <= r_any;
            r_out_force <= r_force;
            r_out_ssr   <= r_ssr;
            r_out_rel   <= r_rel;
            for (int k = 0; k < 8; k++) begin
                r_out_duty[k] <= duty_snap[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign o_out.valid             = r_out_valid;
    assign o_out.any_change        = r_out_any;
    assign o_out.force_manual_mask = r_out_force;
    assign o_out.ssr_on_mask       = r_out_ssr;
    assign o_out.release_auto_mask = r_out_rel;
    assign o_out.duty_ch0          = r_out_duty[0];
    assign o_out.duty_ch1          = r_out_duty[1];
    assign o_out.duty_ch2          = r_out_duty[2];
    assign o_out.duty_ch3          = r_out_duty[3];
    assign o_out.duty_ch4          = r_out_duty[4];
    assign o_out.duty_ch5          = r_out_duty[5];
    assign o_out.duty_ch6          = r_out_duty[6];
    assign o_out.duty_ch7          = r_out_duty[7];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DCC_ASSERT_NXT(a_not_ready_skips, in_acc && !r_dev_ready, r_state == dcc_pkg::ST_FINISH, "device not ready but scan started")
    `DCC_ASSERT_IMP(a_div_bound, r_state == dcc_pkg::ST_DIV_STEP, {1'b0, r_rem} < {r_dvs, 1'b0}, "divider remainder out of range")
    `DCC_ASSERT_IMP(a_out_from_finish, $rose(r_out_valid), $past(r_state == dcc_pkg::ST_FINISH), "result loaded outside finish")
    `DCC_ASSERT_IMP(a_ch_range, r_state == dcc_pkg::ST_SCAN, r_ch <= dcc_pkg::CH_W'(dcc_pkg::CHANNELS - 1), "channel pointer past last channel")

endmodule
